// ===== sv/hsvgrb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to GRB converter package
// Word types, sector codes and the shared arithmetic helpers.
// ----------------------------------------------------------------------------
package hsvgrb_pkg;

  localparam logic [10:0] HUE_SPAN   = 11'd1536;
  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam int          LVL_W      = 8;
  localparam int          DIV_BITS_PER_STAGE = 2;
  localparam int          DIV_STAGES = LVL_W / DIV_BITS_PER_STAGE;
  localparam int          LANES      = 3;
  localparam int          LANE_GREEN = 0;
  localparam int          LANE_RED   = 1;
  localparam int          LANE_BLUE  = 2;

  typedef enum logic [2:0] {
    SEC_R_G_UP = 3'd0,
    SEC_G_R_DN = 3'd1,
    SEC_G_B_UP = 3'd2,
    SEC_B_G_DN = 3'd3,
    SEC_B_R_UP = 3'd4,
    SEC_R_B_DN = 3'd5
  } sector_t;

  typedef struct packed {
    logic [9:0]  led_index;
    logic [10:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  led_slot;
    logic [7:0]  green_level;
    logic [7:0]  red_level;
    logic [7:0]  blue_level;
  } out_word_t;

  typedef struct packed {
    logic [LVL_W-1:0] rem;
    logic [LVL_W-1:0] dq;
  } div_lane_t;

  // Exact x / 255 for x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // Two restoring division steps; the dividend shifts out of dq as the
  // quotient bits shift in.
  function automatic div_lane_t div_steps(input div_lane_t cur, input logic [LVL_W-1:0] d);
    div_lane_t      nxt;
    logic [LVL_W:0] part;
    nxt = cur;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      part   = {nxt.rem, nxt.dq[LVL_W-1]};
      nxt.dq = {nxt.dq[LVL_W-2:0], 1'b0};
      if (part >= {1'b0, d}) begin
        part      = part - {1'b0, d};
        nxt.dq[0] = 1'b1;
      end
      nxt.rem = part[LVL_W-1:0];
    end
    return nxt;
  endfunction

endpackage

// ===== sv/hsv_to_grb_color_converter_top.sv =====
// ----------------------------------------------------------------------------
// HSV to GRB color converter
// Converts one HSV pixel word per clock, unless stalled, into a GRB word with its LED index.
//
// Input words arrive on in_valid/in_word and are taken when in_stall is low.
// Results leave on out_valid/out_word and are taken when out_stall is low.
// A word with a hue of 1536 or more is taken and dropped without a result.
// The brightness divisor is written on cfg_valid/cfg_data; cfg_ready is
// always high, and writes belong in idle periods only. A divisor of zero
// acts as one.
// From acceptance to out_valid a word passes through four stages of
// multiply and divide-by-255 and four stages of a two-bit-per-stage
// restoring divider. Throughput is one word per cycle while out_stall is low.
// When the receiver stalls, each stage holds only while its successor is
// full, so bubbles close up before in_stall rises. Reset is synchronous,
// empties the pipeline and sets the divisor to one.
// ----------------------------------------------------------------------------
module hsv_to_grb_color_converter_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hsvgrb_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hsvgrb_pkg::out_word_t out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);

  localparam int NSTG = 4 + hsvgrb_pkg::DIV_STAGES;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] go;
  logic [7:0]      div_r;
  logic [7:0]      div_eff;
  logic            in_keep;

  logic [9:0]  slot1_r, slot2_r, slot3_r, slot4_r;
  logic [2:0]  sec1_r, sec2_r, sec3_r, sec4_r;
  logic        gray1_r, gray2_r, gray3_r, gray4_r;
  logic [7:0]  v1_r, v2_r, v3_r, v4_r;
  logic [15:0] pfl1_r, pr1_r, pf1_r;
  logic [7:0]  fl2_r, a2_r, b2_r;
  logic [7:0]  fl3_r;
  logic [15:0] mr3_r, mf3_r;
  logic [7:0]  fl4_r, rise4_r, fall4_r;

  logic [9:0]                  slotd_r [hsvgrb_pkg::DIV_STAGES];
  hsvgrb_pkg::div_lane_t       lane_r  [hsvgrb_pkg::DIV_STAGES][hsvgrb_pkg::LANES];
  hsvgrb_pkg::div_lane_t       lane_in [hsvgrb_pkg::LANES];
  logic [7:0]                  lvl     [hsvgrb_pkg::LANES];

  assign cfg_ready = 1'b1;
  assign div_eff   = (div_r == 8'd0) ? 8'd1 : div_r;
  assign in_keep   = in_valid && (in_word.hue < hsvgrb_pkg::HUE_SPAN);
  assign in_stall  = !go[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      div_r <= cfg_data;
    end
  end

  always_comb begin
    go[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      go[k] = !vld_r[k] || go[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) begin
        vld_r[0] <= in_keep;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (go[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      slot1_r <= in_word.led_index;
      sec1_r  <= in_word.hue[10:8];
      gray1_r <= (in_word.saturation == 8'd0);
      v1_r    <= in_word.brightness;
      pfl1_r  <= 16'(in_word.brightness) *
                 16'(hsvgrb_pkg::FULL_SCALE - in_word.saturation);
      pr1_r   <= 16'(in_word.saturation) * 16'(in_word.hue[7:0]);
      pf1_r   <= 16'(in_word.saturation) *
                 16'(hsvgrb_pkg::FULL_SCALE - in_word.hue[7:0]);
    end
    if (go[1]) begin
      slot2_r <= slot1_r;
      sec2_r  <= sec1_r;
      gray2_r <= gray1_r;
      v2_r    <= v1_r;
      fl2_r   <= hsvgrb_pkg::div255(pfl1_r);
      a2_r    <= hsvgrb_pkg::div255(pr1_r);
      b2_r    <= hsvgrb_pkg::div255(pf1_r);
    end
    if (go[2]) begin
      slot3_r <= slot2_r;
      sec3_r  <= sec2_r;
      gray3_r <= gray2_r;
      v3_r    <= v2_r;
      fl3_r   <= fl2_r;
      mr3_r   <= 16'(v2_r) * 16'(a2_r);
      mf3_r   <= 16'(v2_r) * 16'(b2_r);
    end
    if (go[3]) begin
      slot4_r <= slot3_r;
      sec4_r  <= sec3_r;
      gray4_r <= gray3_r;
      v4_r    <= v3_r;
      fl4_r   <= fl3_r;
      rise4_r <= hsvgrb_pkg::div255(mr3_r);
      fall4_r <= hsvgrb_pkg::div255(mf3_r);
    end
  end

  always_comb begin
    if (gray4_r) begin
      lvl[hsvgrb_pkg::LANE_RED]   = v4_r;
      lvl[hsvgrb_pkg::LANE_GREEN] = v4_r;
      lvl[hsvgrb_pkg::LANE_BLUE]  = v4_r;
    end else begin
      case (hsvgrb_pkg::sector_t'(sec4_r))
        hsvgrb_pkg::SEC_R_G_UP: begin
          lvl[hsvgrb_pkg::LANE_RED]   = v4_r;
          lvl[hsvgrb_pkg::LANE_GREEN] = rise4_r;
          lvl[hsvgrb_pkg::LANE_BLUE]  = fl4_r;
        end
        hsvgrb_pkg::SEC_G_R_DN: begin
          lvl[hsvgrb_pkg::LANE_RED]   = fall4_r;
          lvl[hsvgrb_pkg::LANE_GREEN] = v4_r;
          lvl[hsvgrb_pkg::LANE_BLUE]  = fl4_r;
        end
        hsvgrb_pkg::SEC_G_B_UP: begin
          lvl[hsvgrb_pkg::LANE_RED]   = fl4_r;
          lvl[hsvgrb_pkg::LANE_GREEN] = v4_r;
          lvl[hsvgrb_pkg::LANE_BLUE]  = rise4_r;
        end
        hsvgrb_pkg::SEC_B_G_DN: begin
          lvl[hsvgrb_pkg::LANE_RED]   = fl4_r;
          lvl[hsvgrb_pkg::LANE_GREEN] = fall4_r;
          lvl[hsvgrb_pkg::LANE_BLUE]  = v4_r;
        end
        hsvgrb_pkg::SEC_B_R_UP: begin
          lvl[hsvgrb_pkg::LANE_RED]   = rise4_r;
          lvl[hsvgrb_pkg::LANE_GREEN] = fl4_r;
          lvl[hsvgrb_pkg::LANE_BLUE]  = v4_r;
        end
        default: begin
          lvl[hsvgrb_pkg::LANE_RED]   = v4_r;
          lvl[hsvgrb_pkg::LANE_GREEN] = fl4_r;
          lvl[hsvgrb_pkg::LANE_BLUE]  = fall4_r;
        end
      endcase
    end
    for (int l = 0; l < hsvgrb_pkg::LANES; l++) begin
      lane_in[l].rem = '0;
      lane_in[l].dq  = lvl[l];
    end
  end

  always_ff @(posedge clk) begin
    if (go[4]) begin
      slotd_r[0] <= slot4_r;
      for (int l = 0; l < hsvgrb_pkg::LANES; l++) begin
        lane_r[0][l] <= hsvgrb_pkg::div_steps(lane_in[l], div_eff);
      end
    end
    for (int s = 1; s < hsvgrb_pkg::DIV_STAGES; s++) begin
      if (go[4+s]) begin
        slotd_r[s] <= slotd_r[s-1];
        for (int l = 0; l < hsvgrb_pkg::LANES; l++) begin
          lane_r[s][l] <= hsvgrb_pkg::div_steps(lane_r[s-1][l], div_eff);
        end
      end
    end
  end

  assign out_valid            = vld_r[NSTG-1];
  assign out_word.led_slot    = slotd_r[hsvgrb_pkg::DIV_STAGES-1];
  assign out_word.green_level =
    lane_r[hsvgrb_pkg::DIV_STAGES-1][hsvgrb_pkg::LANE_GREEN].dq;
  assign out_word.red_level   =
    lane_r[hsvgrb_pkg::DIV_STAGES-1][hsvgrb_pkg::LANE_RED].dq;
  assign out_word.blue_level  =
    lane_r[hsvgrb_pkg::DIV_STAGES-1][hsvgrb_pkg::LANE_BLUE].dq;

  a_keep_valid_hue: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.hue < hsvgrb_pkg::HUE_SPAN) |=> vld_r[0])
    else $error("An accepted word with a valid hue did not enter the pipeline.");

  a_drop_bad_hue: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !(in_word.hue < hsvgrb_pkg::HUE_SPAN) |=> !vld_r[0])
    else $error("A word with an out-of-range hue entered the pipeline.");

  a_first_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && !go[1] |=> vld_r[0])
    else $error("The first stage lost a word while its successor was blocked.");

  a_out_from_last_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[NSTG-2]))
    else $error("The output became valid without a word in the stage before it.");

endmodule
